// ===== rtl/psmct_pkg.sv =====
// shared constants and types for the ps/2 mouse cursor tracker
package psmct_pkg;

  localparam int COORD_BITS = 10;
  localparam int SIZE_BITS  = 11;
  localparam int OUT_BITS   = 10;
  localparam int BYTE_BITS  = 8;
  localparam int CFG_INDEX_BITS = 2;
  // signed working width for position arithmetic and size compares
  localparam int CALC_W = ((COORD_BITS > SIZE_BITS) ? COORD_BITS : SIZE_BITS) + 2;

  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 2'd1;

  localparam logic [SIZE_BITS-1:0] WIDTH_RESET  = 11'd320;
  localparam logic [SIZE_BITS-1:0] HEIGHT_RESET = 11'd200;

  // flags byte bit positions
  localparam int FIRST_MARK_BIT = 3;
  localparam int X_SIGN_BIT     = 4;
  localparam int Y_SIGN_BIT     = 5;
  localparam int X_OVF_BIT      = 6;
  localparam int Y_OVF_BIT      = 7;

  localparam logic [CALC_W-1:0] OVF_EXTRA = CALC_W'(255);

  typedef struct packed {
    logic [SIZE_BITS-1:0] width;
    logic [SIZE_BITS-1:0] height;
  } screen_size_t;

  typedef struct packed {
    logic                 valid;
    logic [BYTE_BITS-1:0] data;
  } byte_stage_t;

endpackage

// ===== rtl/psmct_byte_if.sv =====
// handshake channel for mouse bytes
interface psmct_byte_if;
  import psmct_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [BYTE_BITS-1:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

// ===== rtl/psmct_cursor_if.sv =====
// result channel carrying the clamped cursor position
interface psmct_cursor_if;
  import psmct_pkg::*;
  logic                valid;
  logic                ready;
  logic [OUT_BITS-1:0] cursor_x;
  logic [OUT_BITS-1:0] cursor_y;
  modport source (output valid, output cursor_x, output cursor_y, input ready);
  modport sink (input valid, input cursor_x, input cursor_y, output ready);
endinterface

// ===== rtl/psmct_cfg_if.sv =====
// register write channel
interface psmct_cfg_if;
  import psmct_pkg::*;
  logic                      valid;
  logic                      ready;
  logic [CFG_INDEX_BITS-1:0] index;
  logic [SIZE_BITS-1:0]      data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

// ===== rtl/psmct_cfg_regs.sv =====
// screen size registers
module psmct_cfg_regs
  import psmct_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  psmct_cfg_if.sink     cfg,
  output screen_size_t  size
);

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      size.width  <= WIDTH_RESET;
      size.height <= HEIGHT_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_SCREEN_WIDTH:  size.width  <= cfg.data;
        REG_SCREEN_HEIGHT: size.height <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/psmct_input_stage.sv =====
// input register for incoming mouse bytes
module psmct_input_stage
  import psmct_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  psmct_byte_if.sink    byte_in,
  input  logic          take,
  output byte_stage_t   stage
);

  assign byte_in.ready = !stage.valid || take;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage.valid <= 1'b0;
    end else if (byte_in.ready) begin
      stage.valid <= byte_in.valid;
    end
    if (byte_in.ready && byte_in.valid) begin
      stage.data <= byte_in.data_byte;
    end
  end

endmodule

// ===== rtl/psmct_packet_core.sv =====
// packet assembly, cursor update, clamping and result register
module psmct_packet_core
  import psmct_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  input  byte_stage_t     stage,
  input  screen_size_t    size,
  output logic            take,
  psmct_cursor_if.source  cursor_out
);

  typedef enum logic [1:0] {
    PH_FIRST  = 2'd0,
    PH_SECOND = 2'd1,
    PH_THIRD  = 2'd2
  } phase_t;

  localparam logic [CALC_W-1:0] SIZE_MIN = CALC_W'(2);
  localparam logic [CALC_W-1:0] SIZE_TOP = CALC_W'(1) << COORD_BITS;

  phase_t                 phase;
  logic [BYTE_BITS-1:0]   flags_byte;
  logic [BYTE_BITS-1:0]   x_delta_byte;
  logic [COORD_BITS-1:0]  pos_x;
  logic [COORD_BITS-1:0]  pos_y;
  logic [COORD_BITS-1:0]  pos_x_next;
  logic [COORD_BITS-1:0]  pos_y_next;
  logic                   out_valid;
  logic                   out_free;
  logic                   third;

  function automatic logic [CALC_W-1:0] magnitude(input logic [BYTE_BITS-1:0] b,
                                                  input logic neg, input logic ovf);
    logic [BYTE_BITS-1:0] m8;
    logic [CALC_W-1:0]    m;
    m8 = neg ? BYTE_BITS'(0 - b) : b;
    m  = CALC_W'(m8);
    if (ovf) m = m + OVF_EXTRA;
    return m;
  endfunction

  function automatic logic [CALC_W-1:0] eff_size(input logic [SIZE_BITS-1:0] r);
    logic [CALC_W-1:0] s;
    s = CALC_W'(r);
    if (s < SIZE_MIN) s = SIZE_MIN;
    else if (s > SIZE_TOP) s = SIZE_TOP;
    return s;
  endfunction

  function automatic logic [COORD_BITS-1:0] clamp_axis(input logic signed [CALC_W-1:0] p,
                                                       input logic [CALC_W-1:0] s);
    logic signed [CALC_W-1:0] q;
    q = p;
    if (q < 0) q = '0;
    if (q > $signed(s - CALC_W'(1))) q = $signed(s - CALC_W'(2));
    return q[COORD_BITS-1:0];
  endfunction

  // third byte completes a packet and needs the result slot
  assign out_free = !out_valid || cursor_out.ready;
  assign third    = (phase == PH_THIRD);
  assign take     = stage.valid && (!third || out_free);

  always_comb begin
    logic signed [CALC_W-1:0] x;
    logic signed [CALC_W-1:0] y;
    logic [CALC_W-1:0]        mx;
    logic [CALC_W-1:0]        my;
    mx = magnitude(x_delta_byte, flags_byte[X_SIGN_BIT], flags_byte[X_OVF_BIT]);
    my = magnitude(stage.data, flags_byte[Y_SIGN_BIT], flags_byte[Y_OVF_BIT]);
    x  = $signed(CALC_W'(pos_x));
    y  = $signed(CALC_W'(pos_y));
    if (flags_byte[X_SIGN_BIT]) x = x - $signed(mx);
    else x = x + $signed(mx);
    // screen y grows downward
    if (flags_byte[Y_SIGN_BIT]) y = y + $signed(my);
    else y = y - $signed(my);
    pos_x_next = clamp_axis(x, eff_size(size.width));
    pos_y_next = clamp_axis(y, eff_size(size.height));
  end

  assign cursor_out.valid    = out_valid;

  always_ff @(posedge clk) begin
    logic [CALC_W-1:0] wide_x;
    logic [CALC_W-1:0] wide_y;
    wide_x = CALC_W'(pos_x_next);
    wide_y = CALC_W'(pos_y_next);
    if (rst) begin
      phase        <= PH_FIRST;
      flags_byte   <= '0;
      x_delta_byte <= '0;
      pos_x        <= '0;
      pos_y        <= '0;
      out_valid    <= 1'b0;
    end else begin
      out_valid <= (out_valid && !cursor_out.ready) || (take && third);
      if (take) begin
        case (phase)
          PH_SECOND: begin
            x_delta_byte <= stage.data;
            phase        <= PH_THIRD;
          end
          PH_THIRD: begin
            phase               <= PH_FIRST;
            pos_x               <= pos_x_next;
            pos_y               <= pos_y_next;
            cursor_out.cursor_x <= wide_x[OUT_BITS-1:0];
            cursor_out.cursor_y <= wide_y[OUT_BITS-1:0];
          end
          default: begin
            // only a byte with the mark bit starts a packet
            if (stage.data[FIRST_MARK_BIT]) begin
              flags_byte <= stage.data;
              phase      <= PH_SECOND;
            end
          end
        endcase
      end
    end
  end

endmodule

// ===== rtl/ps2_mouse_cursor_tracker.sv =====
// top level of the ps/2 mouse cursor tracker
//
//   channel     dir  handshake      payload
//   byte_in     in   valid/ready    data_byte[7:0]
//   cursor_out  out  valid/ready    cursor_x[9:0], cursor_y[9:0]
//   cfg         in   valid/ready    index[1:0], data[10:0] (0 width, 1 height)
//
// one byte per cycle is accepted while byte_in does not stall; a result is valid after
// the third byte of a packet is accepted (input register, then result register).
// the single result register sets the rate: while it is full and not taken,
// a third byte waits in the input register and byte_in stalls behind it.
// reset (rst, synchronous) clears the cursor to 0,0, waits for a first byte
// and loads the sizes 320 by 200; cfg is always ready.
module ps2_mouse_cursor_tracker
  import psmct_pkg::*;
(
  input  logic            clk,
  input  logic            rst,
  psmct_byte_if.sink      byte_in,
  psmct_cursor_if.source  cursor_out,
  psmct_cfg_if.sink       cfg
);

  screen_size_t size;
  byte_stage_t  stage;
  logic         take;

  psmct_cfg_regs u_cfg_regs (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .size (size)
  );

  psmct_input_stage u_input_stage (
    .clk     (clk),
    .rst     (rst),
    .byte_in (byte_in),
    .take    (take),
    .stage   (stage)
  );

  psmct_packet_core u_packet_core (
    .clk        (clk),
    .rst        (rst),
    .stage      (stage),
    .size       (size),
    .take       (take),
    .cursor_out (cursor_out)
  );

endmodule
